>>> hw/rtl/bicubic_patch_evaluator_assert.svh
// ----------------------------------------------------------------------------
// bicubic_patch_evaluator_assert.svh
// Assertion macros shared by the evaluator checkers
// ----------------------------------------------------------------------------
`ifndef BICUBIC_PATCH_EVALUATOR_ASSERT_SVH
`define BICUBIC_PATCH_EVALUATOR_ASSERT_SVH

// same-cycle implication, held off during reset
`define BPE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define BPE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/bpe_pkg.sv
// ----------------------------------------------------------------------------
// bpe_pkg
// Shared types, constants and helpers of the bicubic patch evaluator
// ----------------------------------------------------------------------------
package bpe_pkg;

  // default parameter values
  localparam int MAX_POINTS_X_DEF = 32;
  localparam int MAX_POINTS_Y_DEF = 32;
  localparam int FRAC_BITS_DEF    = 16;

  // coefficient store geometry
  localparam int STORE_DEPTH = 16384;
  localparam int STORE_AW    = 14;
  localparam int CELL_AW     = STORE_AW - 4;
  localparam int Q_W         = 32;

  // register field widths
  localparam int CFG_IDX_W  = 3;
  localparam int STEP_W     = 31;
  localparam int POINTS_W   = 6;
  localparam int POINTS_MIN = 3;

  // shared multiplier and saturation widths
  localparam int OPND_W = 33;
  localparam int PROD_W = 2 * OPND_W;
  localparam int SAT_W  = PROD_W + 2;

  localparam logic signed [Q_W-1:0]   Q_MAX_32 = 32'sh7FFF_FFFF;
  localparam logic signed [Q_W-1:0]   Q_MIN_32 = 32'sh8000_0000;
  localparam logic signed [SAT_W-1:0] SAT_HI   = SAT_W'(Q_MAX_32);
  localparam logic signed [SAT_W-1:0] SAT_LO   = SAT_W'(Q_MIN_32);

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_EVAL = 1'b1
  } bpe_op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_X = 3'd0,
    CFG_START_Y = 3'd1,
    CFG_STEP_X  = 3'd2,
    CFG_STEP_Y  = 3'd3,
    CFG_RECIP_X = 3'd4,
    CFG_RECIP_Y = 3'd5,
    CFG_PTS_X   = 3'd6,
    CFG_PTS_Y   = 3'd7
  } bpe_cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_IDX_X,
    ST_IDX_Y,
    ST_OFF_X,
    ST_OFF_Y,
    ST_BASE,
    ST_CELL,
    ST_H_MUL,
    ST_H_ADD,
    ST_O_MUL,
    ST_O_ADD
  } bpe_state_t;

  typedef enum logic [2:0] {
    MUL_IDX_X,
    MUL_IDX_Y,
    MUL_OFF_X,
    MUL_OFF_Y,
    MUL_BASE,
    MUL_INNER,
    MUL_OUTER
  } bpe_mul_sel_t;

  typedef struct packed {
    logic         ram_we;
    logic         eval_go;
    bpe_mul_sel_t mul_sel;
    logic         ld_i;
    logic         ld_j;
    logic         ld_dx;
    logic         ld_dy;
    logic         ld_cell;
    logic         acc_upd;
    logic         res_upd;
    logic [1:0]   coef_a;
    logic [1:0]   coef_b;
  } bpe_cmd_t;

  // clip a wide signed value to the 32-bit signed range
  function automatic logic signed [Q_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
    logic signed [Q_W-1:0] r;
    if (v > SAT_HI) begin
      r = Q_MAX_32;
    end else if (v < SAT_LO) begin
      r = Q_MIN_32;
    end else begin
      r = Q_W'(v);
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/bicubic_patch_evaluator.sv
// ----------------------------------------------------------------------------
// bicubic_patch_evaluator
// Piecewise bicubic surface evaluation over a rectangular grid
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: a transaction is taken at a clock edge with start high and
//   busy low. in_op selects a coefficient load (in_coef_addr, in_coef_value)
//   or an evaluation at (in_point_x, in_point_y).
//   A load is written in the accepting cycle; busy stays low and no result
//   follows, so loads may be issued back to back.
//   An evaluation raises busy; out_valid pulses for one cycle with out_value
//   in the cycle in which busy is low again, and from then on a new
//   transaction can be taken. Steps: cell search and offsets (index x, index y,
//   offset x, offset y, base, cell), then 20 multiply-add steps, each a
//   multiply and an add, on the single shared 33 x 33 multiplier.
//   The result receiver cannot stall; out_value is valid only with out_valid.
//   Configuration: cfg_we writes cfg_wdata to register cfg_index at once;
//   write only while busy is low.
//   Reset (rst_n low, synchronous) returns the configuration registers to
//   their defaults and the sequencer to idle; the coefficient store keeps no
//   reset value and must be loaded before use, no clearing pass is run.
// ----------------------------------------------------------------------------
module bicubic_patch_evaluator #(
  parameter int MAX_POINTS_X = bpe_pkg::MAX_POINTS_X_DEF,
  parameter int MAX_POINTS_Y = bpe_pkg::MAX_POINTS_Y_DEF,
  parameter int FRAC_BITS    = bpe_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic                             in_op,
  input  logic [bpe_pkg::STORE_AW-1:0]     in_coef_addr,
  input  logic signed [bpe_pkg::Q_W-1:0]   in_coef_value,
  input  logic signed [bpe_pkg::Q_W-1:0]   in_point_x,
  input  logic signed [bpe_pkg::Q_W-1:0]   in_point_y,
  output logic                             out_valid,
  output logic signed [bpe_pkg::Q_W-1:0]   out_value,
  input  logic                             cfg_we,
  input  logic [bpe_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bpe_pkg::Q_W-1:0]          cfg_wdata
);

  bpe_pkg::bpe_cmd_t cmd;

  // sequencer
  bpe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_op     (in_op),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  // arithmetic, registers and coefficient store
  bpe_datapath #(
    .MAX_POINTS_X (MAX_POINTS_X),
    .MAX_POINTS_Y (MAX_POINTS_Y),
    .FRAC_BITS    (FRAC_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_coef_addr  (in_coef_addr),
    .in_coef_value (in_coef_value),
    .in_point_x    (in_point_x),
    .in_point_y    (in_point_y),
    .cmd           (cmd),
    .out_value     (out_value)
  );

endmodule

>>> hw/rtl/bpe_ram.sv
// ----------------------------------------------------------------------------
// bpe_ram
// Generic simple dual-port RAM, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module bpe_ram #(
  parameter int WIDTH = bpe_pkg::Q_W,
  parameter int DEPTH = bpe_pkg::STORE_DEPTH
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/bpe_ctrl.sv
// ----------------------------------------------------------------------------
// bpe_ctrl
// Sequencer: accepts transactions and steps the datapath through the
// cell search, the offsets and the nested Horner evaluation
// ----------------------------------------------------------------------------
module bpe_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               in_op,
  output logic               busy,
  output logic               out_valid,
  output bpe_pkg::bpe_cmd_t  cmd
);

  bpe_pkg::bpe_state_t state_r, state_nxt;
  logic [1:0]          a_r, a_nxt;
  logic [1:0]          b_r, b_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                accept;

  // state and counter registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bpe_pkg::ST_IDLE;
      a_r         <= '0;
      b_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      a_r         <= a_nxt;
      b_r         <= b_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy      = (state_r != bpe_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign accept    = start && !busy;

  // next state and datapath commands
  always_comb begin
    state_nxt     = state_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    out_valid_nxt = 1'b0;
    cmd           = '0;
    cmd.mul_sel   = bpe_pkg::MUL_INNER;
    cmd.coef_a    = a_r;
    cmd.coef_b    = b_r;

    unique case (state_r)
      bpe_pkg::ST_IDLE: begin
        if (accept) begin
          if (bpe_pkg::bpe_op_t'(in_op) == bpe_pkg::OP_EVAL) begin
            cmd.eval_go = 1'b1;
            a_nxt       = 2'd3;
            b_nxt       = 2'd3;
            state_nxt   = bpe_pkg::ST_IDX_X;
          end else begin
            cmd.ram_we  = 1'b1;
          end
        end
      end
      bpe_pkg::ST_IDX_X: begin
        cmd.mul_sel = bpe_pkg::MUL_IDX_X;
        state_nxt   = bpe_pkg::ST_IDX_Y;
      end
      bpe_pkg::ST_IDX_Y: begin
        cmd.mul_sel = bpe_pkg::MUL_IDX_Y;
        cmd.ld_i    = 1'b1;
        state_nxt   = bpe_pkg::ST_OFF_X;
      end
      bpe_pkg::ST_OFF_X: begin
        cmd.mul_sel = bpe_pkg::MUL_OFF_X;
        cmd.ld_j    = 1'b1;
        state_nxt   = bpe_pkg::ST_OFF_Y;
      end
      bpe_pkg::ST_OFF_Y: begin
        cmd.mul_sel = bpe_pkg::MUL_OFF_Y;
        cmd.ld_dx   = 1'b1;
        state_nxt   = bpe_pkg::ST_BASE;
      end
      bpe_pkg::ST_BASE: begin
        cmd.mul_sel = bpe_pkg::MUL_BASE;
        cmd.ld_dy   = 1'b1;
        state_nxt   = bpe_pkg::ST_CELL;
      end
      bpe_pkg::ST_CELL: begin
        cmd.ld_cell = 1'b1;
        state_nxt   = bpe_pkg::ST_H_MUL;
      end
      // inner loop over dy powers, coefficient read issued with the multiply
      bpe_pkg::ST_H_MUL: begin
        cmd.mul_sel = bpe_pkg::MUL_INNER;
        state_nxt   = bpe_pkg::ST_H_ADD;
      end
      bpe_pkg::ST_H_ADD: begin
        cmd.acc_upd = 1'b1;
        if (b_r == 2'd0) begin
          state_nxt = bpe_pkg::ST_O_MUL;
        end else begin
          b_nxt     = b_r - 2'd1;
          state_nxt = bpe_pkg::ST_H_MUL;
        end
      end
      // outer loop over dx powers
      bpe_pkg::ST_O_MUL: begin
        cmd.mul_sel = bpe_pkg::MUL_OUTER;
        state_nxt   = bpe_pkg::ST_O_ADD;
      end
      bpe_pkg::ST_O_ADD: begin
        cmd.res_upd = 1'b1;
        if (a_r == 2'd0) begin
          out_valid_nxt = 1'b1;
          state_nxt     = bpe_pkg::ST_IDLE;
        end else begin
          a_nxt     = a_r - 2'd1;
          b_nxt     = 2'd3;
          state_nxt = bpe_pkg::ST_H_MUL;
        end
      end
      default: begin
        state_nxt = bpe_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

>>> hw/rtl/bpe_datapath.sv
// ----------------------------------------------------------------------------
// bpe_datapath
// Configuration registers, coefficient store, shared multiplier and the
// saturating fixed-point arithmetic of the evaluator
// ----------------------------------------------------------------------------
module bpe_datapath #(
  parameter int MAX_POINTS_X = bpe_pkg::MAX_POINTS_X_DEF,
  parameter int MAX_POINTS_Y = bpe_pkg::MAX_POINTS_Y_DEF,
  parameter int FRAC_BITS    = bpe_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [bpe_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [bpe_pkg::Q_W-1:0]              cfg_wdata,
  input  logic [bpe_pkg::STORE_AW-1:0]         in_coef_addr,
  input  logic signed [bpe_pkg::Q_W-1:0]       in_coef_value,
  input  logic signed [bpe_pkg::Q_W-1:0]       in_point_x,
  input  logic signed [bpe_pkg::Q_W-1:0]       in_point_y,
  input  bpe_pkg::bpe_cmd_t                    cmd,
  output logic signed [bpe_pkg::Q_W-1:0]       out_value
);

  localparam int NXW       = $clog2(MAX_POINTS_X + 1);
  localparam int NYW       = $clog2(MAX_POINTS_Y + 1);
  localparam int IXW       = $clog2(MAX_POINTS_X - 1);
  localparam int IYW       = $clog2(MAX_POINTS_Y - 1);
  localparam int IDX_SHIFT = 2 * FRAC_BITS;
  localparam int QW        = bpe_pkg::Q_W;
  localparam int OW        = bpe_pkg::OPND_W;
  localparam int PW        = bpe_pkg::PROD_W;
  localparam int SW        = bpe_pkg::SAT_W;
  localparam int STW       = bpe_pkg::STEP_W;
  localparam int PTW       = bpe_pkg::POINTS_W;
  localparam int CAW       = bpe_pkg::CELL_AW;
  localparam logic [STW-1:0] ONE_Q = STW'(1) << FRAC_BITS;

  // configuration registers
  logic signed [QW-1:0] start_x_r, start_y_r;
  logic [STW-1:0]       step_x_r, step_y_r, recip_x_r, recip_y_r;
  logic [PTW-1:0]       points_x_r, points_y_r;

  // evaluation registers
  logic signed [QW-1:0] px_r, py_r;
  logic signed [PW-1:0] prod_r, prod_nxt;
  logic [IXW-1:0]       i_r, i_nxt;
  logic [IYW-1:0]       j_r, j_nxt;
  logic signed [QW-1:0] dx_r, dx_nxt, dy_r, dy_nxt;
  logic signed [QW-1:0] acc_r, acc_nxt, res_r, res_nxt;
  logic [CAW-1:0]       cell_r, cell_nxt;

  // combinational helpers
  logic [NXW-1:0]       nx;
  logic [NYW-1:0]       ny, ny_m1;
  logic [IXW-1:0]       lim_x;
  logic [IYW-1:0]       lim_y;
  logic signed [OW-1:0] off_x, off_y, mul_a, mul_b;
  logic [PW-1:0]        idx_wide;
  logic signed [PW-1:0] q_wide;
  logic signed [QW-1:0] q_sat;
  logic [QW-1:0]        ram_rdata;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_x_r  <= '0;
      start_y_r  <= '0;
      step_x_r   <= ONE_Q;
      step_y_r   <= ONE_Q;
      recip_x_r  <= ONE_Q;
      recip_y_r  <= ONE_Q;
      points_x_r <= PTW'(bpe_pkg::POINTS_MIN);
      points_y_r <= PTW'(bpe_pkg::POINTS_MIN);
    end else if (cfg_we) begin
      unique case (bpe_pkg::bpe_cfg_idx_t'(cfg_index))
        bpe_pkg::CFG_START_X: start_x_r  <= $signed(cfg_wdata);
        bpe_pkg::CFG_START_Y: start_y_r  <= $signed(cfg_wdata);
        bpe_pkg::CFG_STEP_X:  step_x_r   <= cfg_wdata[STW-1:0];
        bpe_pkg::CFG_STEP_Y:  step_y_r   <= cfg_wdata[STW-1:0];
        bpe_pkg::CFG_RECIP_X: recip_x_r  <= cfg_wdata[STW-1:0];
        bpe_pkg::CFG_RECIP_Y: recip_y_r  <= cfg_wdata[STW-1:0];
        bpe_pkg::CFG_PTS_X:   points_x_r <= cfg_wdata[PTW-1:0];
        bpe_pkg::CFG_PTS_Y:   points_y_r <= cfg_wdata[PTW-1:0];
        default: ;
      endcase
    end
  end

  // grid node counts clamped to the supported range
  always_comb begin
    if (points_x_r < PTW'(bpe_pkg::POINTS_MIN)) begin
      nx = NXW'(bpe_pkg::POINTS_MIN);
    end else if (int'(points_x_r) > MAX_POINTS_X) begin
      nx = NXW'(MAX_POINTS_X);
    end else begin
      nx = NXW'(points_x_r);
    end
    if (points_y_r < PTW'(bpe_pkg::POINTS_MIN)) begin
      ny = NYW'(bpe_pkg::POINTS_MIN);
    end else if (int'(points_y_r) > MAX_POINTS_Y) begin
      ny = NYW'(MAX_POINTS_Y);
    end else begin
      ny = NYW'(points_y_r);
    end
    lim_x = IXW'(nx - NXW'(2));
    lim_y = IYW'(ny - NYW'(2));
    ny_m1 = ny - NYW'(1);
  end

  // offsets from the grid start for the cell search
  assign off_x = OW'(px_r) - OW'(start_x_r);
  assign off_y = OW'(py_r) - OW'(start_y_r);

  // shared multiplier operand select
  always_comb begin
    unique case (cmd.mul_sel)
      bpe_pkg::MUL_IDX_X: begin
        mul_a = (off_x > 0) ? off_x : '0;
        mul_b = OW'(recip_x_r);
      end
      bpe_pkg::MUL_IDX_Y: begin
        mul_a = (off_y > 0) ? off_y : '0;
        mul_b = OW'(recip_y_r);
      end
      bpe_pkg::MUL_OFF_X: begin
        mul_a = OW'(i_r);
        mul_b = OW'(step_x_r);
      end
      bpe_pkg::MUL_OFF_Y: begin
        mul_a = OW'(j_r);
        mul_b = OW'(step_y_r);
      end
      bpe_pkg::MUL_BASE: begin
        mul_a = OW'(i_r);
        mul_b = OW'(ny_m1);
      end
      bpe_pkg::MUL_INNER: begin
        mul_a = OW'(acc_r);
        mul_b = OW'(dy_r);
      end
      bpe_pkg::MUL_OUTER: begin
        mul_a = OW'(dx_r);
        mul_b = OW'(res_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_nxt = mul_a * mul_b;

  // cell index: product is never negative here, clamp to the last cell
  assign idx_wide = PW'(prod_r >>> IDX_SHIFT);
  assign i_nxt    = (idx_wide > PW'(lim_x)) ? lim_x : IXW'(idx_wide);
  assign j_nxt    = (idx_wide > PW'(lim_y)) ? lim_y : IYW'(idx_wide);

  // local offsets against the cell origin
  assign dx_nxt = bpe_pkg::sat32(SW'(px_r) - SW'(start_x_r) - SW'(prod_r));
  assign dy_nxt = bpe_pkg::sat32(SW'(py_r) - SW'(start_y_r) - SW'(prod_r));

  // cell number wraps with the store
  assign cell_nxt = CAW'(prod_r) + CAW'(j_r);

  // fixed-point product, floor shift then clip
  assign q_wide  = prod_r >>> FRAC_BITS;
  assign q_sat   = bpe_pkg::sat32(SW'(q_wide));
  assign acc_nxt = bpe_pkg::sat32(SW'(q_sat) + SW'($signed(ram_rdata)));
  assign res_nxt = bpe_pkg::sat32(SW'(q_sat) + SW'(acc_r));

  // evaluation registers
  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    if (cmd.eval_go) begin
      px_r  <= in_point_x;
      py_r  <= in_point_y;
      acc_r <= '0;
      res_r <= '0;
    end
    if (cmd.ld_i) begin
      i_r <= i_nxt;
    end
    if (cmd.ld_j) begin
      j_r <= j_nxt;
    end
    if (cmd.ld_dx) begin
      dx_r <= dx_nxt;
    end
    if (cmd.ld_dy) begin
      dy_r <= dy_nxt;
    end
    if (cmd.ld_cell) begin
      cell_r <= cell_nxt;
    end
    if (cmd.acc_upd) begin
      acc_r <= acc_nxt;
    end
    if (cmd.res_upd) begin
      res_r <= res_nxt;
      acc_r <= '0;
    end
  end

  // coefficient store
  bpe_ram #(
    .WIDTH (QW),
    .DEPTH (bpe_pkg::STORE_DEPTH)
  ) u_coef_ram (
    .clk   (clk),
    .we    (cmd.ram_we),
    .waddr (in_coef_addr),
    .wdata (in_coef_value),
    .raddr ({cell_r, cmd.coef_a, cmd.coef_b}),
    .rdata (ram_rdata)
  );

  assign out_value = res_r;

endmodule

>>> hw/rtl/bpe_checker.sv
// ----------------------------------------------------------------------------
// bpe_checker
// Port-level checks of the evaluator transaction sequencing
// ----------------------------------------------------------------------------
`include "bicubic_patch_evaluator_assert.svh"

module bpe_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic in_op,
  input logic out_valid
);

  // results come as single-cycle pulses
  `BPE_ASSERT_NEXT(a_single_pulse, out_valid, !out_valid, "result strobe held over two cycles")

  // a result is shown only once the block is free again
  `BPE_ASSERT_NOW(a_done_idle, out_valid, !busy, "result strobe while busy")

  // an accepted evaluation occupies the block
  `BPE_ASSERT_NEXT(a_eval_busy, start && !busy && in_op, busy, "evaluation did not raise busy")

  // a finished evaluation always delivers its result
  `BPE_ASSERT_NOW(a_fall_result, $fell(busy) && $past(rst_n), out_valid, "busy dropped without a result")

endmodule

bind bicubic_patch_evaluator bpe_checker u_bpe_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_op     (in_op),
  .out_valid (out_valid)
);

>>> verif/bicubic_patch_evaluator_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bicubic_patch_evaluator_test
// Self-checking bench for the bicubic patch evaluator: coefficient loads and
// point evaluations go through a start/busy driver, every returned value is
// checked against a fixed-point surface predictor, across several grid setups
// ----------------------------------------------------------------------------
module bicubic_patch_evaluator_test;
  import bpe_pkg::*;

  typedef longint unsigned u64_t;

  typedef struct packed {
    bpe_op_t         op;
    logic [STORE_AW-1:0] addr;
    logic [Q_W-1:0]  value;
    logic [Q_W-1:0]  px;
    logic [Q_W-1:0]  py;
  } patch_cmd_t;

  localparam int          CLK_HALF     = 6;
  localparam longint      RUN_LIMIT_NS = 5_000_000;
  localparam int unsigned ADDR_MASK    = STORE_DEPTH - 1;

  // block ports
  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    start = 1'b0;
  logic                    busy;
  logic                    in_op = 1'b0;
  logic [STORE_AW-1:0]     in_coef_addr = '0;
  logic signed [Q_W-1:0]   in_coef_value = '0;
  logic signed [Q_W-1:0]   in_point_x = '0;
  logic signed [Q_W-1:0]   in_point_y = '0;
  logic                    out_valid;
  logic signed [Q_W-1:0]   out_value;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [Q_W-1:0]          cfg_wdata = '0;

  // grid registers as the block should hold them
  longint           org_x = 0;
  longint           org_y = 0;
  logic [30:0]      pitch_x = 31'h1_0000;
  logic [30:0]      pitch_y = 31'h1_0000;
  logic [30:0]      inv_x = 31'h1_0000;
  logic [30:0]      inv_y = 31'h1_0000;
  logic [5:0]       nodes_x = 6'd3;
  logic [5:0]       nodes_y = 6'd3;
  logic signed [Q_W-1:0] coef_mem [0:STORE_DEPTH-1];

  // stimulus bookkeeping
  bit               filled [0:STORE_DEPTH-1];
  patch_cmd_t       cmd_q [$];
  patch_cmd_t       drv_cmd;
  logic [Q_W-1:0]   surface_q [$];
  logic [Q_W-1:0]   want_value;
  int unsigned      issued = 0;
  int unsigned      last_base = 0;
  int unsigned      mismatches = 0;
  bit               taken = 1'b0;
  bit               steady = 1'b0;

  bicubic_patch_evaluator dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_op        (in_op),
    .in_coef_addr (in_coef_addr),
    .in_coef_value(in_coef_value),
    .in_point_x   (in_point_x),
    .in_point_y   (in_point_y),
    .out_valid    (out_valid),
    .out_value    (out_value),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic longint clip32(longint v);
    if (v > longint'(Q_MAX_32)) return longint'(Q_MAX_32);
    if (v < longint'(Q_MIN_32)) return longint'(Q_MIN_32);
    return v;
  endfunction

  // fixed-point product, floor rounding, saturated
  function automatic longint fx_mul(longint a, longint b);
    longint p;
    p = a * b;
    return clip32(p >>> FRAC_BITS_DEF);
  endfunction

  function automatic int unsigned span(logic [5:0] n, int unsigned top);
    if (n < POINTS_MIN) return POINTS_MIN;
    if (n > top) return top;
    return 32'(n);
  endfunction

  // cell index along one axis, negative offsets land on cell zero
  function automatic u64_t node_index(longint p, longint org, logic [30:0] inv,
                                      int unsigned n);
    longint off;
    u64_t   idx;
    off = p - org;
    idx = 0;
    if (off > 0) idx = (u64_t'(off) * inv) >> (2 * FRAC_BITS_DEF);
    if (idx > n - 2) idx = u64_t'(n - 2);
    return idx;
  endfunction

  // cell base address and local offsets of a point
  function automatic void locate(input logic [Q_W-1:0] px, py,
                                 output longint dx, dy, output int unsigned base);
    longint      x;
    longint      y;
    int unsigned nx;
    int unsigned ny;
    u64_t        i;
    u64_t        j;
    x  = longint'($signed(px));
    y  = longint'($signed(py));
    nx = span(nodes_x, MAX_POINTS_X_DEF);
    ny = span(nodes_y, MAX_POINTS_Y_DEF);
    i  = node_index(x, org_x, inv_x, nx);
    j  = node_index(y, org_y, inv_y, ny);
    dx = clip32(x - (org_x + longint'(i * pitch_x)));
    dy = clip32(y - (org_y + longint'(j * pitch_y)));
    base = 32'(16 * (i * (ny - 1) + j));
  endfunction

  // nested horner: inner over dy, outer over dx
  function automatic logic [Q_W-1:0] surface_at(logic [Q_W-1:0] px, py);
    longint      dx;
    longint      dy;
    longint      sum;
    longint      acc;
    int unsigned base;
    int unsigned addr;
    locate(px, py, dx, dy, base);
    sum = 0;
    for (int a = 3; a >= 0; a--) begin
      acc = 0;
      for (int b = 3; b >= 0; b--) begin
        addr = (base + 4 * a + b) & ADDR_MASK;
        acc  = clip32(fx_mul(acc, dy) + longint'(coef_mem[addr]));
      end
      sum = clip32(fx_mul(dx, sum) + acc);
    end
    return sum[Q_W-1:0];
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [Q_W-1:0] d);
    case (bpe_cfg_idx_t'(idx))
      CFG_START_X: org_x = longint'($signed(d));
      CFG_START_Y: org_y = longint'($signed(d));
      CFG_STEP_X:  pitch_x = d[30:0];
      CFG_STEP_Y:  pitch_y = d[30:0];
      CFG_RECIP_X: inv_x = d[30:0];
      CFG_RECIP_Y: inv_y = d[30:0];
      CFG_PTS_X:   nodes_x = d[5:0];
      CFG_PTS_Y:   nodes_y = d[5:0];
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------- driver

  // present one transaction at a time, hold start until it is taken
  always @(negedge clk) begin
    if (rst_n && (!start || taken)) begin
      if (cmd_q.size() != 0 && (steady || $urandom_range(0, 99) >= 36)) begin
        drv_cmd = cmd_q.pop_front();
        in_op         <= drv_cmd.op;
        in_coef_addr  <= drv_cmd.addr;
        in_coef_value <= drv_cmd.value;
        in_point_x    <= drv_cmd.px;
        in_point_y    <= drv_cmd.py;
        start         <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk) begin
    taken <= rst_n && start && !busy;
    if (rst_n) begin
      // check each result against the oldest predicted value
      if (out_valid) begin
        if (surface_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result: value %h", out_value);
        end else begin
          want_value = surface_q.pop_front();
          if (out_value !== want_value) begin
            mismatches++;
            if (mismatches <= 10)
              $display("value mismatch: expected %h, got %h", want_value, out_value);
          end
        end
      end
      // track register writes
      if (cfg_we) apply_reg(cfg_index, cfg_wdata);
      // accepted transaction
      if (start && !busy) begin
        if (in_op == OP_LOAD) coef_mem[in_coef_addr] = in_coef_value;
        else surface_q.push_back(surface_at(in_point_x, in_point_y));
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  function automatic logic [Q_W-1:0] rand_coef();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return ($urandom_range(0, 1) != 0) ? Q_MAX_32 : Q_MIN_32;
      default: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
    endcase
  endfunction

  // coordinate mostly near the first nodes, sometimes anywhere
  function automatic logic [Q_W-1:0] rand_coord(longint org, logic [30:0] pitch,
                                                int unsigned n);
    longint      v;
    int unsigned node;
    node = ($urandom_range(0, 7) == 0) ? $urandom_range(0, n + 1) : $urandom_range(0, 2);
    case ($urandom_range(0, 9))
      0: v = longint'($signed($urandom));
      1: v = ($urandom_range(0, 1) != 0) ? longint'(Q_MAX_32) : longint'(Q_MIN_32);
      2: v = org - longint'($urandom_range(1, pitch + 1));
      default: v = org + longint'(node) * longint'(pitch) + longint'($urandom_range(0, pitch));
    endcase
    v = clip32(v);
    return v[Q_W-1:0];
  endfunction

  task automatic push_load(int unsigned addr, logic [Q_W-1:0] value);
    patch_cmd_t c;
    c       = '0;
    c.op    = OP_LOAD;
    c.addr  = addr[STORE_AW-1:0];
    c.value = value;
    cmd_q.push_back(c);
    filled[addr & ADDR_MASK] = 1'b1;
    issued++;
  endtask

  // evaluation, preceded by loads of any cell word not yet written
  task automatic push_eval(logic [Q_W-1:0] px, logic [Q_W-1:0] py);
    patch_cmd_t  c;
    longint      dx;
    longint      dy;
    int unsigned base;
    int unsigned addr;
    locate(px, py, dx, dy, base);
    for (int k = 0; k < 16; k++) begin
      addr = (base + k) & ADDR_MASK;
      if (!filled[addr]) push_load(addr, rand_coef());
    end
    c    = '0;
    c.op = OP_EVAL;
    c.px = px;
    c.py = py;
    cmd_q.push_back(c);
    last_base = base;
    issued++;
  endtask

  task automatic random_items(int unsigned count);
    int unsigned stop;
    int unsigned roll;
    stop = issued + count;
    while (issued < stop) begin
      roll = $urandom_range(0, 99);
      if (roll < 20) begin
        push_load($urandom_range(0, STORE_DEPTH - 1), rand_coef());
      end else if (roll < 30) begin
        // rewrite a word of the cell used last
        push_load((last_base + $urandom_range(0, 15)) & ADDR_MASK, rand_coef());
      end else begin
        push_eval(rand_coord(org_x, pitch_x, span(nodes_x, MAX_POINTS_X_DEF)),
                  rand_coord(org_y, pitch_y, span(nodes_y, MAX_POINTS_Y_DEF)));
      end
    end
  endtask

  task automatic write_reg(bpe_cfg_idx_t idx, logic [Q_W-1:0] d);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= d;
  endtask

  task automatic set_grid(logic [Q_W-1:0] sx, sy, stx, sty, rx, ry, nx, ny);
    write_reg(CFG_START_X, sx);
    write_reg(CFG_START_Y, sy);
    write_reg(CFG_STEP_X, stx);
    write_reg(CFG_STEP_Y, sty);
    write_reg(CFG_RECIP_X, rx);
    write_reg(CFG_RECIP_Y, ry);
    write_reg(CFG_PTS_X, nx);
    write_reg(CFG_PTS_Y, ny);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic setup_phase(int ph);
    logic [Q_W-1:0] stx;
    logic [Q_W-1:0] sty;
    case (ph)
      1: set_grid(32'hFFFE_0000, 32'h0001_8000, 32'h0000_8000, 32'h0000_4000,
                  32'h0002_0000, 32'h0004_0000, 32'd8, 32'd5);
      // extreme origins and spacing, largest grid
      2: set_grid(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  32'd1, 32'd1, 32'd32, 32'd32);
      // node counts out of range, tiny spacing, huge reciprocal
      3: set_grid(32'd0, 32'h0001_0000, 32'd1, 32'd1,
                  32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd63, 32'd0);
      // zero spacing and zero reciprocal
      4: set_grid($urandom, $urandom, 32'd0, 32'd0, 32'd0, 32'd0, 32'd2, 32'd1);
      5: begin
        stx = $urandom_range(32'h100, 32'h4_0000);
        sty = $urandom_range(32'h100, 32'h4_0000);
        set_grid($urandom, $urandom, {1'($urandom), stx[30:0]}, {1'($urandom), sty[30:0]},
                 32'(64'h1_0000_0000 / stx), 32'(64'h1_0000_0000 / sty),
                 {26'($urandom_range(0, 32'h3FF_FFFF)), 6'($urandom_range(3, 32))},
                 {26'($urandom_range(0, 32'h3FF_FFFF)), 6'($urandom_range(3, 32))});
      end
      default: begin
        // spacing and reciprocal that do not agree
        set_grid($urandom_range(0, 32'h0020_0000) - 32'h0010_0000,
                 $urandom_range(0, 32'h0020_0000) - 32'h0010_0000,
                 $urandom_range(1, 32'h0010_0000), $urandom_range(1, 32'h0010_0000),
                 $urandom_range(0, 32'h0010_0000), $urandom_range(0, 32'h0010_0000),
                 $urandom_range(0, 63), $urandom_range(0, 63));
      end
    endcase
  endtask

  // wait until every queued transaction is taken and every value has come back
  task automatic wait_quiet();
    do @(posedge clk); while (cmd_q.size() != 0 || start || surface_q.size() != 0);
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // directed: cell zero with extreme coefficients, top store address
    for (int k = 0; k < 16; k++) begin
      if (k == 0) push_load(k, Q_MAX_32);
      else if (k == 15) push_load(k, Q_MIN_32);
      else push_load(k, rand_coef());
    end
    push_load(STORE_DEPTH - 1, 32'd0);
    push_eval(32'd0, 32'd0);
    push_eval(Q_MIN_32, Q_MIN_32);
    push_eval(Q_MIN_32, 32'h0000_8000);
    push_eval(32'h0000_FFFF, 32'h0000_FFFF);
    push_eval(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    random_items(60);

    // further grid setups, written only while the block is idle
    for (int ph = 1; ph <= 6; ph++) begin
      wait_quiet();
      repeat (4) @(negedge clk);
      setup_phase(ph);
      steady = (ph == 2);
      random_items(70);
    end

    wait_quiet();
    repeat (60) @(negedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    #RUN_LIMIT_NS;
    $display("status: fail");
    $finish;
  end

endmodule
